@@ design/lli_pkg.sv @@
// shared types and constants for the line intersection pipeline
// no dependencies; used by every module of the block
package lli_pkg;

  // width of the parallel threshold register
  localparam int THR_W = 33;

  // fallback coordinate for parallel lines, in whole units
  localparam longint FALLBACK_INT = -10000;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_PAR = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  // control bits that travel with each transaction
  typedef struct packed {
    logic valid;
    logic par;
  } ctl_t;

endpackage

@@ design/lli_coef.sv @@
// line coefficients A, B, C and the determinant, three register stages
// depends on lli_pkg for the control struct
module lli_coef #(
  parameter int W = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [W-1:0]      ax1,
  input  logic signed [W-1:0]      ay1,
  input  logic signed [W-1:0]      ax2,
  input  logic signed [W-1:0]      ay2,
  input  logic signed [W-1:0]      bx1,
  input  logic signed [W-1:0]      by1,
  input  logic signed [W-1:0]      bx2,
  input  logic signed [W-1:0]      by2,
  output lli_pkg::ctl_t            ctl_out,
  output logic signed [W:0]        a_a,
  output logic signed [W:0]        b_a,
  output logic signed [W:0]        a_b,
  output logic signed [W:0]        b_b,
  output logic signed [2*W+1:0]    c_a,
  output logic signed [2*W+1:0]    c_b,
  output logic signed [2*W+2:0]    det
);

  localparam int AW = W + 1;
  localparam int CW = 2 * AW;

  // stage 1 registers
  logic              v1;
  logic signed [AW-1:0] a_a1, b_a1, a_b1, b_b1;
  logic signed [W-1:0]  ax1_1, ay1_1, bx1_1, by1_1;

  // stage 2 registers
  logic              v2;
  logic signed [AW-1:0] a_a2, b_a2, a_b2, b_b2;
  logic signed [AW+W-1:0] m_ax, m_ay, m_bx, m_by;
  logic signed [CW-1:0] m_d1, m_d2;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ctl_out <= '0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      ctl_out.valid <= v2;
      ctl_out.par <= 1'b0;
    end
  end

  // stage 1: coordinate differences
  always_ff @(posedge clk) begin
    a_a1 <= $signed({ay2[W-1], ay2}) - $signed({ay1[W-1], ay1});
    b_a1 <= $signed({ax1[W-1], ax1}) - $signed({ax2[W-1], ax2});
    a_b1 <= $signed({by2[W-1], by2}) - $signed({by1[W-1], by1});
    b_b1 <= $signed({bx1[W-1], bx1}) - $signed({bx2[W-1], bx2});
    ax1_1 <= ax1;
    ay1_1 <= ay1;
    bx1_1 <= bx1;
    by1_1 <= by1;
  end

  // stage 2: products for C and det
  always_ff @(posedge clk) begin
    m_ax <= a_a1 * ax1_1;
    m_ay <= b_a1 * ay1_1;
    m_bx <= a_b1 * bx1_1;
    m_by <= b_b1 * by1_1;
    m_d1 <= a_b1 * b_a1;
    m_d2 <= a_a1 * b_b1;
    a_a2 <= a_a1;
    b_a2 <= b_a1;
    a_b2 <= a_b1;
    b_b2 <= b_b1;
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    c_a <= $signed({m_ax[AW+W-1], m_ax}) + $signed({m_ay[AW+W-1], m_ay});
    c_b <= $signed({m_bx[AW+W-1], m_bx}) + $signed({m_by[AW+W-1], m_by});
    det <= $signed({m_d1[CW-1], m_d1}) - $signed({m_d2[CW-1], m_d2});
    a_a <= a_a2;
    b_a <= b_a2;
    a_b <= a_b2;
    b_b <= b_b2;
  end

endmodule

@@ design/lli_numer.sv @@
// numerators by split multiplies, parallel test, magnitudes and signs
// depends on lli_pkg for the control struct and threshold width
module lli_numer #(
  parameter int W = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lli_pkg::THR_W-1:0]   thr,
  input  lli_pkg::ctl_t               ctl_in,
  input  logic signed [W:0]           a_a,
  input  logic signed [W:0]           b_a,
  input  logic signed [W:0]           a_b,
  input  logic signed [W:0]           b_b,
  input  logic signed [2*W+1:0]       c_a,
  input  logic signed [2*W+1:0]       c_b,
  input  logic signed [2*W+2:0]       det,
  output lli_pkg::ctl_t               ctl_out,
  output logic [3*W+3:0]              mag_x,
  output logic [3*W+3:0]              mag_y,
  output logic                        neg_x,
  output logic                        neg_y,
  output logic [2*W+2:0]              den_mag
);

  localparam int AW = W + 1;
  localparam int PW = 3 * AW;
  localparam int NW = 3 * AW + 1;
  localparam int DW = 2 * AW + 1;
  localparam int CMPW = (DW > lli_pkg::THR_W) ? DW : lli_pkg::THR_W;

  lli_pkg::ctl_t c4, c5, c6;
  logic [DW-1:0] dm4, dm5, dm6;
  logic dn4, dn5, dn6;

  // partial products: low half unsigned, high half signed
  logic signed [2*AW:0]   l_bacb, l_bbca, l_abca, l_aacb;
  logic signed [2*AW-1:0] h_bacb, h_bbca, h_abca, h_aacb;
  logic signed [PW-1:0]   f_bacb, f_bbca, f_abca, f_aacb;
  logic signed [NW-1:0]   nx, ny;

  logic [DW-1:0] det_mag_n;
  logic          par_n;

  // determinant magnitude and parallel test
  always_comb begin
    det_mag_n = det[DW-1] ? DW'(-det) : DW'(det);
    par_n = (det == '0) || (CMPW'(det_mag_n) < CMPW'(thr));
  end

  // control chain
  always_ff @(posedge clk) begin
    if (rst) begin
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
      ctl_out <= '0;
    end else begin
      c4.valid <= ctl_in.valid;
      c4.par <= par_n;
      c5 <= c4;
      c6 <= c5;
      ctl_out <= c6;
    end
  end

  // stage 4: partial products
  always_ff @(posedge clk) begin
    l_bacb <= b_a * $signed({1'b0, c_b[AW-1:0]});
    h_bacb <= b_a * $signed(c_b[2*AW-1:AW]);
    l_bbca <= b_b * $signed({1'b0, c_a[AW-1:0]});
    h_bbca <= b_b * $signed(c_a[2*AW-1:AW]);
    l_abca <= a_b * $signed({1'b0, c_a[AW-1:0]});
    h_abca <= a_b * $signed(c_a[2*AW-1:AW]);
    l_aacb <= a_a * $signed({1'b0, c_b[AW-1:0]});
    h_aacb <= a_a * $signed(c_b[2*AW-1:AW]);
    dm4 <= det_mag_n;
    dn4 <= det[DW-1];
  end

  // stage 5: recombine halves
  always_ff @(posedge clk) begin
    f_bacb <= $signed({h_bacb, {AW{1'b0}}}) + $signed({{(AW-1){l_bacb[2*AW]}}, l_bacb});
    f_bbca <= $signed({h_bbca, {AW{1'b0}}}) + $signed({{(AW-1){l_bbca[2*AW]}}, l_bbca});
    f_abca <= $signed({h_abca, {AW{1'b0}}}) + $signed({{(AW-1){l_abca[2*AW]}}, l_abca});
    f_aacb <= $signed({h_aacb, {AW{1'b0}}}) + $signed({{(AW-1){l_aacb[2*AW]}}, l_aacb});
    dm5 <= dm4;
    dn5 <= dn4;
  end

  // stage 6: numerators
  always_ff @(posedge clk) begin
    nx <= $signed({f_bacb[PW-1], f_bacb}) - $signed({f_bbca[PW-1], f_bbca});
    ny <= $signed({f_abca[PW-1], f_abca}) - $signed({f_aacb[PW-1], f_aacb});
    dm6 <= dm5;
    dn6 <= dn5;
  end

  // stage 7: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    mag_x <= nx[NW-1] ? NW'(-nx) : NW'(nx);
    mag_y <= ny[NW-1] ? NW'(-ny) : NW'(ny);
    neg_x <= nx[NW-1] ^ dn6;
    neg_y <= ny[NW-1] ^ dn6;
    den_mag <= dm6;
  end

endmodule

@@ design/lli_quot.sv @@
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on lli_pkg for the control struct
module lli_quot #(
  parameter int W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lli_pkg::ctl_t         ctl_in,
  input  logic [3*W+3:0]        num_mag,
  input  logic                  neg,
  input  logic [2*W+2:0]        den_mag,
  output lli_pkg::ctl_t         ctl_out,
  output logic signed [W-1:0]   coord,
  output logic                  sat
);

  localparam int NW = 3 * W + 4;
  localparam int DW = 2 * W + 3;

  lli_pkg::ctl_t    ctl  [0:W];
  logic [NW-1:0]    rem  [0:W];
  logic [W-1:0]     q    [0:W];
  logic [DW-1:0]    den  [0:W];
  logic             ng   [0:W];
  logic             ov   [0:W];

  // stage 0: quotient too large for W bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num_mag;
    q[0] <= '0;
    den[0] <= den_mag;
    ng[0] <= neg;
    ov[0] <= (num_mag >= (NW'(den_mag) << W));
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [NW-1:0] dsh;
    logic          take;

    always_comb begin
      dsh = NW'(den[k-1]) << (W - k);
      take = (rem[k-1] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= ctl[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= take ? (rem[k-1] - dsh) : rem[k-1];
      q[k] <= q[k-1] | (take ? (W'(1) << (W - k)) : '0);
      den[k] <= den[k-1];
      ng[k] <= ng[k-1];
      ov[k] <= ov[k-1];
    end
  end

  // final: sign and saturation
  logic sat_n;
  always_comb begin
    if (ng[W]) begin
      sat_n = ov[W] || (q[W][W-1] && (|q[W][W-2:0]));
    end else begin
      sat_n = ov[W] || q[W][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl[W];
    end
  end

  always_ff @(posedge clk) begin
    sat <= sat_n;
    if (sat_n) begin
      coord <= ng[W] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
    end else begin
      coord <= ng[W] ? $signed(W'(-q[W])) : $signed(q[W]);
    end
  end

endmodule

@@ design/line_line_intersection.sv @@
// two-line intersection by Cramer's rule, fully pipelined
// throughput: one transaction per cycle, busy stays low; the divider stages set depth
// reset: synchronous rst clears all valid bits and sets the threshold register thr to 1
// results appear for one cycle with done; the receiver cannot stall
module line_line_intersection #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lli_pkg::THR_W-1:0]        cfg_data,
  input  logic signed [COORD_WIDTH-1:0]    line_a_start_x,
  input  logic signed [COORD_WIDTH-1:0]    line_a_start_y,
  input  logic signed [COORD_WIDTH-1:0]    line_a_end_x,
  input  logic signed [COORD_WIDTH-1:0]    line_a_end_y,
  input  logic signed [COORD_WIDTH-1:0]    line_b_start_x,
  input  logic signed [COORD_WIDTH-1:0]    line_b_start_y,
  input  logic signed [COORD_WIDTH-1:0]    line_b_end_x,
  input  logic signed [COORD_WIDTH-1:0]    line_b_end_y,
  output logic                             done,
  output logic signed [COORD_WIDTH-1:0]    cross_x,
  output logic signed [COORD_WIDTH-1:0]    cross_y,
  output logic [1:0]                       status
);

  localparam int W = COORD_WIDTH;
  localparam longint FB_RAW = lli_pkg::FALLBACK_INT * (64'sd1 <<< FRAC_BITS);
  localparam longint C_MIN = -(64'sd1 <<< (W - 1));
  localparam longint FB = (FB_RAW < C_MIN) ? C_MIN : FB_RAW;
  localparam logic [W-1:0] FB_COORD = FB[W-1:0];

  logic [lli_pkg::THR_W-1:0] thr;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= lli_pkg::THR_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  // coefficients
  lli_pkg::ctl_t ctl_c;
  logic signed [W:0] a_a, b_a, a_b, b_b;
  logic signed [2*W+1:0] c_a, c_b;
  logic signed [2*W+2:0] det;

  lli_coef #(.W(W)) u_coef (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .ax1(line_a_start_x), .ay1(line_a_start_y),
    .ax2(line_a_end_x), .ay2(line_a_end_y),
    .bx1(line_b_start_x), .by1(line_b_start_y),
    .bx2(line_b_end_x), .by2(line_b_end_y),
    .ctl_out(ctl_c), .a_a(a_a), .b_a(b_a), .a_b(a_b), .b_b(b_b),
    .c_a(c_a), .c_b(c_b), .det(det)
  );

  // numerators
  lli_pkg::ctl_t ctl_n;
  logic [3*W+3:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic [2*W+2:0] den_mag;

  lli_numer #(.W(W)) u_numer (
    .clk(clk), .rst(rst), .thr(thr), .ctl_in(ctl_c),
    .a_a(a_a), .b_a(b_a), .a_b(a_b), .b_b(b_b),
    .c_a(c_a), .c_b(c_b), .det(det),
    .ctl_out(ctl_n), .mag_x(mag_x), .mag_y(mag_y),
    .neg_x(neg_x), .neg_y(neg_y), .den_mag(den_mag)
  );

  // dividers, one per coordinate
  lli_pkg::ctl_t ctl_x, ctl_y;
  logic signed [W-1:0] qx, qy;
  logic sat_x, sat_y;

  lli_quot #(.W(W)) u_quot_x (
    .clk(clk), .rst(rst), .ctl_in(ctl_n), .num_mag(mag_x), .neg(neg_x),
    .den_mag(den_mag), .ctl_out(ctl_x), .coord(qx), .sat(sat_x)
  );

  lli_quot #(.W(W)) u_quot_y (
    .clk(clk), .rst(rst), .ctl_in(ctl_n), .num_mag(mag_y), .neg(neg_y),
    .den_mag(den_mag), .ctl_out(ctl_y), .coord(qy), .sat(sat_y)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_x.valid && ctl_y.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_x.par) begin
      cross_x <= $signed(FB_COORD);
      cross_y <= $signed(FB_COORD);
      status <= lli_pkg::ST_PAR;
    end else begin
      cross_x <= qx;
      cross_y <= qy;
      status <= (sat_x || sat_y) ? lli_pkg::ST_SAT : lli_pkg::ST_OK;
    end
  end

endmodule

@@ design/lli_checker.sv @@
// port-level checks for line_line_intersection, attached by bind
// depends on the top level's ports and lli_pkg status codes
module lli_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] cross_x,
  input logic signed [COORD_WIDTH-1:0] cross_y,
  input logic [1:0]                    status
);

  localparam int LAT = COORD_WIDTH + 10;

  // every accepted transaction comes out after the pipeline latency
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted transaction did not complete on time");

  // no result without a transaction accepted earlier
  a_done_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  // status holds a defined code
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == lli_pkg::ST_OK || status == lli_pkg::ST_PAR ||
              status == lli_pkg::ST_SAT))
    else $error("undefined status code");

  // parallel result gives the same fallback on both axes
  a_par_point: assert property (@(posedge clk) disable iff (rst)
    (done && status == lli_pkg::ST_PAR) |-> (cross_x == cross_y))
    else $error("parallel fallback point differs between axes");

endmodule

bind line_line_intersection lli_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lli_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cross_x(cross_x), .cross_y(cross_y), .status(status)
);
